>>> rtl/core/decision_tree_leaf_finder_defines.svh
// assertion macros shared by the rtl files
`ifndef DECISION_TREE_LEAF_FINDER_DEFINES_SVH
`define DECISION_TREE_LEAF_FINDER_DEFINES_SVH

`ifndef SYNTHESIS
// concurrent check on a given clock and active-low reset
`define DTLF_ASSERT_ON(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);
// same check on the block clock and reset
`define DTLF_ASSERT(lbl, prop, msg) \
	`DTLF_ASSERT_ON(lbl, clk, arst_n, prop, msg)
`else
`define DTLF_ASSERT_ON(lbl, ck, rst_n, prop, msg)
`define DTLF_ASSERT(lbl, prop, msg)
`endif

`endif

>>> rtl/core/dtlf_pkg.sv
package dtlf_pkg;

	localparam int unsigned CMD_W       = 2;
	localparam int unsigned ADDR_W      = 8;
	localparam int unsigned FEAT_SEL_W  = 6;
	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned DEPTH_W     = 4;
	localparam int unsigned LEAF_W      = 8;
	localparam int unsigned S_TDATA_W   = 88;
	localparam int unsigned M_TDATA_W   = 8;
	localparam int unsigned QDEPTH      = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_NODE_WR = 2'd0,
		CMD_FEAT_WR = 2'd1,
		CMD_PREDICT = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_NODE_WR,
		OP_FEAT_WR,
		OP_PREDICT
	} op_t;

	// one queued operation, already range checked
	typedef struct packed {
		op_t                   op;
		logic [ADDR_W-1:0]     addr;
		logic [FEAT_SEL_W-1:0] feat;
		logic [VALUE_W-1:0]    value;
	} q_entry_t;

endpackage

>>> rtl/core/dtlf_front.sv
`include "decision_tree_leaf_finder_defines.svh"

module dtlf_front import dtlf_pkg::*; #(
	parameter int unsigned MAX_DEPTH    = 8,
	parameter int unsigned NUM_FEATURES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// node_addr, node_feature, node_threshold, feature_index, feature_value, zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	// cmd
	input  logic [CMD_W-1:0]     s_tuser,
	output logic                 q_valid,
	output q_entry_t             q_head,
	input  logic                 q_pop
);

	localparam int unsigned NODE_SLOTS = (1 << MAX_DEPTH) - 1;

	q_entry_t            q_mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	cmd_t                cmd;
	logic [ADDR_W-1:0]   node_addr;
	logic [FEAT_SEL_W-1:0] node_feature;
	logic [VALUE_W-1:0]  node_threshold;
	logic [FEAT_SEL_W-1:0] feature_index;
	logic [VALUE_W-1:0]  feature_value;
	q_entry_t            entry;
	logic                keep;
	logic                push;

	assign cmd            = cmd_t'(s_tuser);
	assign node_addr      = s_tdata[7:0];
	assign node_feature   = s_tdata[13:8];
	assign node_threshold = s_tdata[45:14];
	assign feature_index  = s_tdata[51:46];
	assign feature_value  = s_tdata[83:52];

	// classify: out of range writes and the unused code are dropped here
	always_comb begin
		entry = '{op: OP_PREDICT, addr: '0, feat: '0, value: '0};
		keep  = 1'b0;
		unique case (cmd)
			CMD_NODE_WR: begin
				entry.op    = OP_NODE_WR;
				entry.addr  = node_addr;
				entry.feat  = node_feature;
				entry.value = node_threshold;
				keep        = 32'(node_addr) < NODE_SLOTS;
			end
			CMD_FEAT_WR: begin
				entry.op    = OP_FEAT_WR;
				entry.addr  = ADDR_W'(feature_index);
				entry.value = feature_value;
				keep        = 32'(feature_index) < NUM_FEATURES;
			end
			CMD_PREDICT: begin
				entry.op = OP_PREDICT;
				keep     = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign s_tready = count_q != QCNT_W'(QDEPTH);
	assign push     = s_tvalid && s_tready && keep;
	assign q_valid  = count_q != '0;
	assign q_head   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(q_pop);
		end
	end

	`DTLF_ASSERT(a_count_bound, count_q <= QCNT_W'(QDEPTH), "queue count beyond depth")
	`DTLF_ASSERT(a_pop_nonempty, q_pop |-> q_valid, "pop from empty queue")
	`DTLF_ASSERT(a_full_no_push, (count_q == QCNT_W'(QDEPTH)) |-> !push, "push into full queue")

endmodule

>>> rtl/core/dtlf_back.sv
`include "decision_tree_leaf_finder_defines.svh"

module dtlf_back import dtlf_pkg::*; #(
	parameter int unsigned MAX_DEPTH    = 8,
	parameter int unsigned NUM_FEATURES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [DEPTH_W-1:0]   levels,
	input  logic                 q_valid,
	input  q_entry_t             q_head,
	output logic                 q_pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int unsigned NODE_SLOTS = (1 << MAX_DEPTH) - 1;
	localparam int unsigned NW         = MAX_DEPTH;
	localparam int unsigned NIW        = MAX_DEPTH + 1;
	localparam int unsigned FW         = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NODE,
		ST_FEAT,
		ST_DONE
	} state_t;

	logic [FEAT_SEL_W-1:0] node_feat_mem [NODE_SLOTS];
	logic [VALUE_W-1:0]    node_thr_mem  [NODE_SLOTS];
	logic [VALUE_W-1:0]    feat_mem      [NUM_FEATURES];

	state_t                state_q;
	logic [DEPTH_W-1:0]    lvl_q;
	logic [DEPTH_W-1:0]    lev_q;
	logic [NIW-1:0]        node_q;
	logic                  m_tvalid_q;
	logic [LEAF_W-1:0]     leaf_q;
	logic                  feat_miss_q;
	logic [FEAT_SEL_W-1:0] node_feat_rd_q;
	logic [VALUE_W-1:0]    node_thr_rd_q;
	logic [VALUE_W-1:0]    feat_rd_q;

	logic                  node_we;
	logic                  feat_we;
	logic                  start;
	logic                  node_rd_en;
	logic [NW-1:0]         node_rd_addr;
	logic                  feat_rd_en;
	logic [VALUE_W-1:0]    feat_val;
	logic                  less;
	logic [NIW-1:0]        node_nxt;
	logic [LEAF_W-1:0]     leaf;
	logic                  out_free;

	assign q_pop   = (state_q == ST_IDLE) && q_valid;
	assign node_we = q_pop && (q_head.op == OP_NODE_WR);
	assign feat_we = q_pop && (q_head.op == OP_FEAT_WR);
	assign start   = q_pop && (q_head.op == OP_PREDICT);

	// missing feature reads as zero
	assign feat_val = feat_miss_q ? '0 : feat_rd_q;
	assign less     = $signed(feat_val) < $signed(node_thr_rd_q);
	assign node_nxt = NIW'((32'(node_q) << 1) + (less ? 32'd1 : 32'd2));

	// node read at the root on start, else at the next node while levels remain
	assign node_rd_en   = (start && (levels != '0))
	                    || ((state_q == ST_FEAT) && (lvl_q != DEPTH_W'(1)));
	assign node_rd_addr = (state_q == ST_FEAT) ? NW'(node_nxt) : '0;
	assign feat_rd_en   = state_q == ST_NODE;

	assign leaf     = LEAF_W'(32'(node_q) - ((32'd1 << lev_q) - 32'd1));
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_feat_mem[NW'(q_head.addr)] <= q_head.feat;
			node_thr_mem[NW'(q_head.addr)]  <= q_head.value;
		end
		if (node_rd_en) begin
			node_feat_rd_q <= node_feat_mem[node_rd_addr];
			node_thr_rd_q  <= node_thr_mem[node_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (feat_we) begin
			feat_mem[FW'(q_head.addr)] <= q_head.value;
		end
		if (feat_rd_en) begin
			feat_rd_q   <= feat_mem[FW'(node_feat_rd_q)];
			feat_miss_q <= 32'(node_feat_rd_q) >= NUM_FEATURES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			lvl_q      <= '0;
			lev_q      <= '0;
			node_q     <= '0;
			m_tvalid_q <= 1'b0;
			leaf_q     <= '0;
		end else begin
			// a new leaf takes the output register as the old one leaves
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						node_q  <= '0;
						lvl_q   <= levels;
						lev_q   <= levels;
						state_q <= (levels == '0) ? ST_DONE : ST_NODE;
					end
				end
				ST_NODE: begin
					state_q <= ST_FEAT;
				end
				ST_FEAT: begin
					node_q  <= node_nxt;
					lvl_q   <= lvl_q - DEPTH_W'(1);
					state_q <= (lvl_q == DEPTH_W'(1)) ? ST_DONE : ST_NODE;
				end
				ST_DONE: begin
					if (out_free) begin
						leaf_q  <= leaf;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = leaf_q;

	`DTLF_ASSERT(a_pop_idle, q_pop |-> (state_q == ST_IDLE), "queue popped mid walk")
	`DTLF_ASSERT(a_feat_lvl, (state_q == ST_FEAT) |-> (lvl_q != '0), "walk past last level")
	`DTLF_ASSERT(a_done_out, ((state_q == ST_DONE) && out_free) |=> m_tvalid_q, "leaf not presented")

endmodule

>>> rtl/core/decision_tree_leaf_finder.sv
// channel  direction  handshake             contents
// s        in         s_tvalid / s_tready   tuser: cmd; tdata: node write, feature write fields
// m        out        m_tvalid / m_tready   tdata: leaf_index
// cfg      in         cfg_valid / cfg_ready cfg_data: depth_in_use
//
// a kept word is registered into a four-deep queue; the front keeps taking words
// while the back works, so s_tready drops only when the queue is full
// writes complete as the back end pops them; a prediction walks L levels, L the depth in use
// (capped at MAX_DEPTH), reading the node store then the feature store at each level
// a finished leaf sits in the output register; a new walk may run while it waits
// reset clears the queue, walk state, output valid and sets depth to one; stores are not cleared
module decision_tree_leaf_finder import dtlf_pkg::*; #(
	parameter int unsigned MAX_DEPTH    = 8,
	parameter int unsigned NUM_FEATURES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// cfg_data: depth_in_use
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [DEPTH_W-1:0]   cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [7:0] node_addr, [13:8] node_feature, [45:14] node_threshold,
	// [51:46] feature_index, [83:52] feature_value, [87:84] zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	// [1:0] cmd
	input  logic [CMD_W-1:0]     s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [7:0] leaf_index
	output logic [M_TDATA_W-1:0] m_tdata
);

	logic [DEPTH_W-1:0] depth_q;
	logic [DEPTH_W-1:0] levels;
	logic               q_valid;
	q_entry_t           q_head;
	logic               q_pop;

	// depth register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			depth_q <= cfg_data;
		end
	end

	// depth beyond the store saturates
	assign levels = (depth_q > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : depth_q;

	// front: decode, range check, queue
	dtlf_front #(
		.MAX_DEPTH    (MAX_DEPTH),
		.NUM_FEATURES (NUM_FEATURES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop)
	);

	// back: stores, tree walk, output register
	dtlf_back #(
		.MAX_DEPTH    (MAX_DEPTH),
		.NUM_FEATURES (NUM_FEATURES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.levels   (levels),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
